[hw/rtl/bdq_pkg.sv]
// Shared types and constants for the bounded deque.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DATA_W      = 32;
  localparam int FILL_W      = 5;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_LIST       = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     is_last;
    logic [1:0]               status;
    logic                     is_empty;
    logic [FILL_W-1:0]        fill;
  } rsp_t;

endpackage

[hw/rtl/bdq_ram.sv]
// Ring storage: one write port and one registered read port.
`timescale 1ns / 1ps

module bdq_ram
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/bdq_ctrl.sv]
// Deque control: head and count registers, command decode and list sequencer.
`timescale 1ns / 1ps

module bdq_ctrl
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  req_t                     req,
  output logic                     busy,
  output logic                     rsp_strobe,
  output rsp_t                     rsp,
  output logic                     wr_en,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [DATA_W-1:0]        wr_data,
  output logic                     rd_en,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [DATA_W-1:0]        rd_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic {S_IDLE, S_LIST} state_t;

  state_t        state;
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] ptr;
  logic [CW-1:0] pos;
  logic [CW-1:0] lim_m1;
  logic          res_vld, res_fire;
  rsp_t          res, res_next;
  logic          list_vld, list_last;
  logic          accept, start_list;

  logic [IW-1:0] head_dec, head_inc, ptr_inc;
  logic [IW:0]   tail_sum;
  logic [IW-1:0] tail;
  logic [CW-1:0] lim;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state == S_LIST);
  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign ptr_inc  = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
  // A push at the back only happens when count is below DEPTH, so the sum
  // stays below twice DEPTH and one subtract wraps it.
  assign tail_sum = (IW+1)'(head) + (IW+1)'(count);
  assign tail     = (tail_sum >= (IW+1)'(DEPTH)) ? IW'(tail_sum - (IW+1)'(DEPTH))
                                                 : IW'(tail_sum);
  assign lim      = (count < MAX_RESULTS) ? count : CW'(MAX_RESULTS);

  always_comb begin
    head_next  = head;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = head;
    wr_data    = req.data_in;
    res_fire   = 1'b0;
    start_list = 1'b0;
    res_next.data_out = '0;
    res_next.is_last  = 1'b1;
    res_next.status   = STAT_OK;
    if (accept) begin
      case (req.cmd)
        CMD_PUSH_FRONT: begin
          res_fire = 1'b1;
          if (count == FULL_CNT) begin
            res_next.status = STAT_FULL;
          end else begin
            head_next  = head_dec;
            count_next = count + 1'b1;
            wr_en      = 1'b1;
            wr_addr    = head_dec;
          end
        end
        CMD_PUSH_BACK: begin
          res_fire = 1'b1;
          if (count == FULL_CNT) begin
            res_next.status = STAT_FULL;
          end else begin
            count_next = count + 1'b1;
            wr_en      = 1'b1;
            wr_addr    = tail;
          end
        end
        CMD_POP_FRONT: begin
          res_fire = 1'b1;
          if (count == '0) begin
            res_next.status = STAT_EMPTY;
          end else begin
            head_next  = head_inc;
            count_next = count - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          res_fire = 1'b1;
          if (count == '0) begin
            res_next.status = STAT_EMPTY;
          end else begin
            count_next = count - 1'b1;
          end
        end
        CMD_LIST: begin
          if (count == '0) begin
            res_fire        = 1'b1;
            res_next.status = STAT_EMPTY;
          end else begin
            start_list = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res_next.is_empty = (count_next == '0);
    res_next.fill     = FILL_W'(count_next);
  end

  assign rd_en   = (state == S_LIST);
  assign rd_addr = ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      res_vld  <= 1'b0;
      list_vld <= 1'b0;
    end else begin
      head     <= head_next;
      count    <= count_next;
      res_vld  <= res_fire;
      res      <= res_next;
      list_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start_list) begin
            state  <= S_LIST;
            ptr    <= head;
            pos    <= '0;
            lim_m1 <= lim - 1'b1;
          end
        end
        S_LIST: begin
          // Read data for this entry lands next cycle, with its flags.
          list_vld  <= 1'b1;
          list_last <= (pos == lim_m1);
          ptr       <= ptr_inc;
          pos       <= pos + 1'b1;
          if (pos == lim_m1) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (list_vld) begin
      rsp.data_out = rd_data;
      rsp.is_last  = list_last;
      rsp.status   = STAT_OK;
      rsp.is_empty = 1'b0;
      rsp.fill     = FILL_W'(count);
    end else begin
      rsp = res;
    end
  end

  assign rsp_strobe = list_vld || res_vld;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count exceeds depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= LAST_IDX)
    else $error("head index out of range");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0))
    else $error("listing an empty queue");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(list_vld && res_vld))
    else $error("list and status results collide");

  a_list_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.cmd == CMD_LIST) && (count != '0)) |=> busy)
    else $error("list command did not start the sequencer");

endmodule

[hw/rtl/bounded_deque_top.sv]
// Bounded double-ended queue of signed 32-bit words: top level.
`timescale 1ns / 1ps

// A command word is taken when start is high and busy is low. Push and pop
// commands keep busy low and return one status word on the cycle after they
// are taken, so one may be issued every cycle. A list of a nonempty queue
// raises busy while it reads min(fill, 16) entries through the ring memory's
// single read port, and returns one word per entry, each in the cycle after
// its read; a list of an empty queue answers like a pop. Results appear on
// rsp for exactly one cycle with rsp_strobe high and cannot be held off.
// No clearing pass follows reset: only entries already written are read.
// Codes 5 to 7 are ignored and give no result.
module bounded_deque_top
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic rsp_strobe,
  output rsp_t rsp
);

  logic                     wr_en;
  logic [$clog2(DEPTH)-1:0] wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic                     rd_en;
  logic [$clog2(DEPTH)-1:0] rd_addr;
  logic [DATA_W-1:0]        rd_data;

  bdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .rsp_strobe (rsp_strobe),
    .rsp        (rsp),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  bdq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

[bench/tb_bounded_deque_top.sv]
// Self-checking testbench for the bounded deque top level.
`timescale 1ns / 1ps

module tb_bounded_deque_top
  import bdq_pkg::*;
();

  // Command codes above list are not decoded by the block.
  localparam logic [2:0] CMD_FIRST_UNUSED = CMD_LIST + 3'd1;
  localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

  // Tracks the deque contents and the result words each accepted command owes.
  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring [DEPTH_DEF];
    int   head;
    int   count;
    rsp_t due_words [$];
    int   errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function void owe(logic signed [DATA_W-1:0] value, logic last, logic [1:0] stat);
      rsp_t w;
      w.data_out = value;
      w.is_last  = last;
      w.status   = stat;
      w.is_empty = (count == 0);
      w.fill     = FILL_W'(count);
      due_words.push_back(w);
    endfunction

    function void note_command(req_t r);
      int n;
      case (r.cmd)
        CMD_PUSH_FRONT: begin
          if (count >= DEPTH_DEF) begin
            owe('0, 1'b1, STAT_FULL);
          end else begin
            head = (head + DEPTH_DEF - 1) % DEPTH_DEF;
            ring[head] = r.data_in;
            count++;
            owe('0, 1'b1, STAT_OK);
          end
        end
        CMD_PUSH_BACK: begin
          if (count >= DEPTH_DEF) begin
            owe('0, 1'b1, STAT_FULL);
          end else begin
            ring[(head + count) % DEPTH_DEF] = r.data_in;
            count++;
            owe('0, 1'b1, STAT_OK);
          end
        end
        CMD_POP_FRONT: begin
          if (count == 0) begin
            owe('0, 1'b1, STAT_EMPTY);
          end else begin
            head = (head + 1) % DEPTH_DEF;
            count--;
            owe('0, 1'b1, STAT_OK);
          end
        end
        CMD_POP_BACK: begin
          if (count == 0) begin
            owe('0, 1'b1, STAT_EMPTY);
          end else begin
            count--;
            owe('0, 1'b1, STAT_OK);
          end
        end
        CMD_LIST: begin
          if (count == 0) begin
            owe('0, 1'b1, STAT_EMPTY);
          end else begin
            n = (count < MAX_RESULTS) ? count : MAX_RESULTS;
            for (int i = 0; i < n; i++)
              owe(ring[(head + i) % DEPTH_DEF], (i == n - 1), STAT_OK);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(rsp_t got);
      rsp_t want;
      if (due_words.size() == 0) begin
        $error("unexpected word: data_out %0d status %0d", got.data_out, got.status);
        errors++;
        return;
      end
      want = due_words.pop_front();
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
        errors++;
      end
      if (got.is_last !== want.is_last) begin
        $error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        errors++;
      end
      if (got.fill !== want.fill) begin
        $error("fill: expected %0d, got %0d", want.fill, got.fill);
        errors++;
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic rsp_strobe;
  rsp_t rsp;

  deque_scoreboard sb;
  bit growing = 1'b1;

  bounded_deque_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .rsp_strobe (rsp_strobe),
    .rsp        (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && rsp_strobe)
      sb.check_word(rsp);
  end

  // Holds the command until the block takes it, then idles each following
  // cycle with the given percentage.
  task automatic issue_command(req_t r, int idle_pct);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
  endtask

  // Alternates between filling and emptying the deque so that both the full
  // and the empty corners are reached with random contents.
  task automatic random_phase(int n_items, int idle_pct);
    req_t r;
    int   roll;
    int   done;
    done = 0;
    while (done < n_items) begin
      if (sb.count >= DEPTH_DEF && $urandom_range(99) < 30)
        growing = 1'b0;
      else if (sb.count == 0 && $urandom_range(99) < 30)
        growing = 1'b1;
      roll      = $urandom_range(99);
      r.data_in = $urandom();
      if (roll < 5) begin
        r.cmd = 3'($urandom_range(int'(CMD_FIRST_UNUSED), int'(CMD_LAST_UNUSED)));
      end else if (roll < 17) begin
        r.cmd = CMD_LIST;
        done++;
      end else begin
        if ((roll < 85) == growing)
          r.cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else
          r.cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        done++;
      end
      issue_command(r, idle_pct);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty-queue answers and ignored codes first.
    issue_command(req_t'{cmd: CMD_LIST,       data_in: 32'sd0}, 0);
    issue_command(req_t'{cmd: CMD_POP_FRONT,  data_in: 32'sd0}, 0);
    issue_command(req_t'{cmd: CMD_POP_BACK,   data_in: -32'sd1}, 0);
    issue_command(req_t'{cmd: CMD_FIRST_UNUSED,        data_in: -32'sd1}, 0);
    issue_command(req_t'{cmd: CMD_FIRST_UNUSED + 3'd1, data_in: 32'sd5}, 0);
    issue_command(req_t'{cmd: CMD_LAST_UNUSED,         data_in: 32'sd9}, 0);
    issue_command(req_t'{cmd: CMD_PUSH_FRONT, data_in: 32'sh7fffffff}, 0);
    issue_command(req_t'{cmd: CMD_PUSH_BACK,  data_in: 32'sh80000000}, 0);
    issue_command(req_t'{cmd: CMD_PUSH_FRONT, data_in: -32'sd1}, 0);
    issue_command(req_t'{cmd: CMD_PUSH_BACK,  data_in: 32'sd0}, 0);
    issue_command(req_t'{cmd: CMD_LIST,       data_in: 32'sd0}, 0);
    issue_command(req_t'{cmd: CMD_POP_FRONT,  data_in: 32'sd3}, 0);
    issue_command(req_t'{cmd: CMD_POP_BACK,   data_in: 32'sd3}, 0);
    issue_command(req_t'{cmd: CMD_LIST,       data_in: -32'sd7}, 0);
    issue_command(req_t'{cmd: CMD_POP_BACK,   data_in: 32'sd0}, 0);
    issue_command(req_t'{cmd: CMD_POP_FRONT,  data_in: 32'sd0}, 0);
    issue_command(req_t'{cmd: CMD_POP_FRONT,  data_in: 32'sd0}, 0);
    drain();

    random_phase(28, 8);
    drain();
    random_phase(28, 69);
    drain();
    random_phase(28, 0);
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("bounded_deque_top regression: pass");
    else
      $display("bounded_deque_top regression: fail");
    $finish;
  end

  initial begin
    #1ms;
    $display("bounded_deque_top regression: fail");
    $finish;
  end

endmodule
